// ===== rtl/core/c2s_pkg.sv =====
package c2s_pkg;

  // Coordinates carry 8 guard bits through both CORDIC passes
  localparam int GUARD_BITS = 8;
  // Angle accumulators: degrees with 32 fraction bits
  localparam int ACC_FRAC  = 32;
  localparam int ACC_W     = 44;
  localparam int MAX_STAGES = 32;
  localparam int GAIN_ENTRIES = 17;
  // Widest coordinate that the side band can hold
  localparam int COORD_MAX = 32;

  // +180 degrees in accumulator format
  localparam logic signed [ACC_W-1:0] DEG180_Q = 44'sd773094113280;

  // atan(2^-i) in degrees, 32 fraction bits
  localparam logic signed [ACC_W-1:0] ATAN_DEG [MAX_STAGES] = '{
    44'sd193273528320, 44'sd114096026022, 44'sd60285206653, 44'sd30601712202,
    44'sd15360239180,  44'sd7687607525,   44'sd3844741810,  44'sd1922488225,
    44'sd961258780,    44'sd480631223,    44'sd240315840,   44'sd120157949,
    44'sd60078978,     44'sd30039489,     44'sd15019745,    44'sd7509872,
    44'sd3754936,      44'sd1877468,      44'sd938734,      44'sd469367,
    44'sd234684,       44'sd117342,       44'sd58671,       44'sd29335,
    44'sd14668,        44'sd7334,         44'sd3667,        44'sd1833,
    44'sd917,          44'sd458,          44'sd229,         44'sd115
  };

  // Inverse CORDIC gain by stage count, 32 fraction bits (saturates at 16)
  localparam logic [31:0] INV_GAIN [GAIN_ENTRIES] = '{
    32'd4294967295, 32'd3037000500, 32'd2716375825, 32'd2635271635,
    32'd2614921743, 32'd2609829388, 32'd2608555990, 32'd2608237621,
    32'd2608158028, 32'd2608138129, 32'd2608133155, 32'd2608131911,
    32'd2608131600, 32'd2608131522, 32'd2608131503, 32'd2608131498,
    32'd2608131496
  };

  // Values that ride alongside the vector through the pipeline
  typedef struct packed {
    logic                          xy_zero;
    logic                          all_zero;
    logic signed [COORD_MAX-1:0]   z;
    logic signed [ACC_W-1:0]       az_acc;
    logic signed [ACC_W-1:0]       el_acc;
  } side_t;

endpackage

// ===== rtl/core/c2s_cordic_stage.sv =====
module c2s_cordic_stage #(
  parameter int DW    = 35,
  parameter int SHIFT = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_vld,
  input  logic signed [DW-1:0]               in_x,
  input  logic signed [DW-1:0]               in_y,
  input  logic signed [c2s_pkg::ACC_W-1:0]   in_ang,
  input  c2s_pkg::side_t                     in_side,
  output logic                               out_vld,
  output logic signed [DW-1:0]               out_x,
  output logic signed [DW-1:0]               out_y,
  output logic signed [c2s_pkg::ACC_W-1:0]   out_ang,
  output c2s_pkg::side_t                     out_side
);
  import c2s_pkg::*;

  logic signed [DW-1:0]    xs;
  logic signed [DW-1:0]    ys;
  logic signed [DW-1:0]    x_next;
  logic signed [DW-1:0]    y_next;
  logic signed [ACC_W-1:0] ang_next;

  // floor shifts of the old vector
  assign xs = in_x >>> SHIFT;
  assign ys = in_y >>> SHIFT;

  // rotate toward the x axis by the sign of y
  always_comb begin
    if (!in_y[DW-1]) begin
      x_next   = in_x + ys;
      y_next   = in_y - xs;
      ang_next = in_ang + ATAN_DEG[SHIFT];
    end else begin
      x_next   = in_x - ys;
      y_next   = in_y + xs;
      ang_next = in_ang - ATAN_DEG[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_ang  <= ang_next;
      out_side <= in_side;
    end
  end

endmodule

// ===== rtl/core/c2s_gain.sv =====
module c2s_gain #(
  parameter int          DW   = 35,
  parameter logic [31:0] GAIN = 32'd2608131496
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic signed [DW-1:0]  in_x,
  input  c2s_pkg::side_t        in_side,
  output logic                  out_vld,
  output logic signed [DW-1:0]  out_x,
  output c2s_pkg::side_t        out_side
);
  import c2s_pkg::*;

  localparam int LO_W = (DW + 1) / 2;
  localparam int HI_W = DW - LO_W;

  logic [LO_W-1:0]    x_lo;
  logic [HI_W-1:0]    x_hi;
  logic [LO_W+31:0]   p_lo;
  logic [HI_W+31:0]   p_hi;
  logic               mid_vld;
  side_t              mid_side;
  logic [DW+31:0]     sum;

  // input is non-negative: split it into two halves for narrow multipliers
  assign x_lo = in_x[LO_W-1:0];
  assign x_hi = in_x[DW-1:LO_W];

  // recombine partial products and drop the 32 gain fraction bits
  assign sum = {p_hi, {LO_W{1'b0}}} + (DW+32)'(p_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      mid_vld <= in_vld;
      out_vld <= mid_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lo     <= x_lo * GAIN;
      p_hi     <= x_hi * GAIN;
      mid_side <= in_side;
      out_x    <= sum[DW+31:32];
      out_side <= mid_side;
    end
  end

endmodule

// ===== rtl/core/cartesian_to_spherical.sv =====
// Pipeline, N = CORDIC_STAGES (capped at 32): one input stage, N CORDIC stages and
// a two-stage gain multiply per pass, and one output register. Throughput: one point
// per cycle while it advances; the whole pipeline advances together whenever the
// last gain stage is empty or the output register is free or being taken.
// Reset (rst, synchronous, active high) clears all valid bits; data is not reset.
module cartesian_to_spherical #(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pos_valid,
  output logic                              pos_ready,
  input  logic signed [COORD_WIDTH-1:0]     pos_x,
  input  logic signed [COORD_WIDTH-1:0]     pos_y,
  input  logic signed [COORD_WIDTH-1:0]     pos_z,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [COORD_WIDTH-1:0]            range_out,
  output logic signed [ANGLE_FRAC_BITS+8:0] azimuth,
  output logic signed [ANGLE_FRAC_BITS+7:0] elevation
);
  import c2s_pkg::*;

  localparam int DW     = COORD_WIDTH + GUARD_BITS + 3;
  localparam int N      = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int GIDX   = (N > GAIN_ENTRIES - 1) ? GAIN_ENTRIES - 1 : N;
  localparam logic [31:0] GAIN = INV_GAIN[GIDX];
  localparam int AZ_W   = ANGLE_FRAC_BITS + 9;
  localparam int EL_W   = ANGLE_FRAC_BITS + 8;
  localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);
  localparam logic signed [ACC_W-1:0] AZ_LIM   = ACC_W'(180) << ANGLE_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] EL_LIM   = ACC_W'(90) << ANGLE_FRAC_BITS;
  localparam logic signed [AZ_W-1:0]  AZ_MAX   = AZ_W'(180) << ANGLE_FRAC_BITS;
  localparam logic signed [EL_W-1:0]  EL_MAX   = EL_W'(90) << ANGLE_FRAC_BITS;
  localparam logic [DW:0] RNG_HALF = (DW+1)'(1) << (GUARD_BITS - 1);

  // pipeline advance: last stage empty, or output register free / being taken
  logic adv;

  // pass 1 chain (x, y)
  logic                    p1_vld  [N+1];
  logic signed [DW-1:0]    p1_x    [N+1];
  logic signed [DW-1:0]    p1_y    [N+1];
  logic signed [ACC_W-1:0] p1_ang  [N+1];
  side_t                   p1_side [N+1];

  // pass 2 chain (horizontal distance, z)
  logic                    p2_vld  [N+1];
  logic signed [DW-1:0]    p2_x    [N+1];
  logic signed [DW-1:0]    p2_y    [N+1];
  logic signed [ACC_W-1:0] p2_ang  [N+1];
  side_t                   p2_side [N+1];

  logic                    g1_vld;
  logic signed [DW-1:0]    g1_x;
  side_t                   g1_in_side;
  side_t                   g1_side;
  side_t                   g2_in_side;
  logic                    g2_vld;
  logic signed [DW-1:0]    g2_x;
  side_t                   g2_side;

  // input stage
  logic signed [DW-1:0]    sx;
  logic signed [DW-1:0]    sy;
  logic                    x_neg;
  side_t                   in_side;

  // output stage
  logic signed [ACC_W-1:0] az_sh;
  logic signed [ACC_W-1:0] el_sh;
  logic signed [ACC_W-1:0] az_clamp;
  logic signed [ACC_W-1:0] el_clamp;
  logic [DW:0]             rng_sum;
  logic [DW:0]             rng_sh;
  logic [COORD_WIDTH-1:0]  range_next;
  logic signed [AZ_W-1:0]  az_next;
  logic signed [EL_W-1:0]  el_next;

  assign adv       = !g2_vld || !res_valid || res_ready;
  assign pos_ready = adv;

  // scale by the guard bits; fold left half-plane vectors into the right one
  assign sx    = DW'(pos_x) <<< GUARD_BITS;
  assign sy    = DW'(pos_y) <<< GUARD_BITS;
  assign x_neg = pos_x[COORD_WIDTH-1];

  always_comb begin
    in_side          = '0;
    in_side.xy_zero  = (pos_x == '0) && (pos_y == '0);
    in_side.all_zero = (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
    in_side.z        = COORD_MAX'(pos_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld[0] <= 1'b0;
    end else if (adv) begin
      p1_vld[0] <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_x[0]    <= x_neg ? -sx : sx;
      p1_y[0]    <= x_neg ? -sy : sy;
      if (!x_neg) begin
        p1_ang[0] <= '0;
      end else if (!pos_y[COORD_WIDTH-1]) begin
        p1_ang[0] <= DEG180_Q;
      end else begin
        p1_ang[0] <= -DEG180_Q;
      end
      p1_side[0] <= in_side;
    end
  end

  // pass 1: azimuth and horizontal distance
  for (genvar i = 0; i < N; i++) begin : g_pass1
    c2s_cordic_stage #(.DW(DW), .SHIFT(i)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (p1_vld[i]),
      .in_x     (p1_x[i]),
      .in_y     (p1_y[i]),
      .in_ang   (p1_ang[i]),
      .in_side  (p1_side[i]),
      .out_vld  (p1_vld[i+1]),
      .out_x    (p1_x[i+1]),
      .out_y    (p1_y[i+1]),
      .out_ang  (p1_ang[i+1]),
      .out_side (p1_side[i+1])
    );
  end

  always_comb begin
    g1_in_side        = p1_side[N];
    g1_in_side.az_acc = p1_ang[N];
  end

  c2s_gain #(.DW(DW), .GAIN(GAIN)) u_gain1 (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (p1_vld[N]),
    .in_x     (p1_x[N]),
    .in_side  (g1_in_side),
    .out_vld  (g1_vld),
    .out_x    (g1_x),
    .out_side (g1_side)
  );

  // pass 2 entry: (horizontal distance, scaled z)
  assign p2_vld[0]  = g1_vld;
  assign p2_x[0]    = g1_x;
  assign p2_y[0]    = DW'($signed(g1_side.z[COORD_WIDTH-1:0])) <<< GUARD_BITS;
  assign p2_ang[0]  = '0;
  assign p2_side[0] = g1_side;

  // pass 2: elevation and range
  for (genvar i = 0; i < N; i++) begin : g_pass2
    c2s_cordic_stage #(.DW(DW), .SHIFT(i)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (p2_vld[i]),
      .in_x     (p2_x[i]),
      .in_y     (p2_y[i]),
      .in_ang   (p2_ang[i]),
      .in_side  (p2_side[i]),
      .out_vld  (p2_vld[i+1]),
      .out_x    (p2_x[i+1]),
      .out_y    (p2_y[i+1]),
      .out_ang  (p2_ang[i+1]),
      .out_side (p2_side[i+1])
    );
  end

  always_comb begin
    g2_in_side        = p2_side[N];
    g2_in_side.el_acc = p2_ang[N];
  end

  c2s_gain #(.DW(DW), .GAIN(GAIN)) u_gain2 (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (p2_vld[N]),
    .in_x     (p2_x[N]),
    .in_side  (g2_in_side),
    .out_vld  (g2_vld),
    .out_x    (g2_x),
    .out_side (g2_side)
  );

  // round angles half up to the output fraction, then clamp
  assign az_sh = (g2_side.az_acc + RND_HALF) >>> RND_SH;
  assign el_sh = (g2_side.el_acc + RND_HALF) >>> RND_SH;

  always_comb begin
    if (az_sh > AZ_LIM) begin
      az_clamp = AZ_LIM;
    end else if (az_sh < -AZ_LIM) begin
      az_clamp = -AZ_LIM;
    end else begin
      az_clamp = az_sh;
    end
    if (el_sh > EL_LIM) begin
      el_clamp = EL_LIM;
    end else if (el_sh < -EL_LIM) begin
      el_clamp = -EL_LIM;
    end else begin
      el_clamp = el_sh;
    end
    az_next = g2_side.xy_zero  ? '0 : AZ_W'(az_clamp);
    el_next = g2_side.all_zero ? '0 : EL_W'(el_clamp);
  end

  // range: drop guard bits with rounding, saturate to the coordinate width
  assign rng_sum = {1'b0, $unsigned(g2_x)} + RNG_HALF;
  assign rng_sh  = rng_sum >> GUARD_BITS;
  assign range_next = (|rng_sh[DW:COORD_WIDTH]) ? '1 : rng_sh[COORD_WIDTH-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= (adv && g2_vld) || (res_valid && !res_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && g2_vld) begin
      range_out <= range_next;
      azimuth   <= az_next;
      elevation <= el_next;
    end
  end

`ifndef SYNTHESIS
  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> pos_ready)
    else $error("input stalled while output register is free");

  a_az_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (azimuth <= AZ_MAX) && (azimuth >= -AZ_MAX))
    else $error("azimuth outside +-180 degrees");

  a_el_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (elevation <= EL_MAX) && (elevation >= -EL_MAX))
    else $error("elevation outside +-90 degrees");
`endif

endmodule

// ===== test/cartesian_to_spherical_tb.sv =====
module cartesian_to_spherical_tb;

  localparam int CW     = 24;
  localparam int AFB    = 16;
  localparam int STAGES = 20;
  localparam int AZW    = AFB + 9;
  localparam int ELW    = AFB + 8;
  localparam int N_USED = (STAGES > c2s_pkg::MAX_STAGES) ? c2s_pkg::MAX_STAGES : STAGES;
  localparam int LATENCY = 2 * N_USED + 6;

  localparam logic signed [CW-1:0] CRD_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CRD_LO = {1'b1, {(CW-1){1'b0}}};

  localparam int N_RANDOM      = 1825;
  localparam int STEADY_LO     = 300;
  localparam int STEADY_HI     = 700;
  localparam int HOLD_AT       = 900;
  localparam int HOLD_CYCLES   = 300;
  localparam int PAUSE_AT      = 1200;
  localparam int TIMEOUT_CYCLES = 200000;

  // One predicted conversion, with the point that produced it
  typedef struct {
    logic signed [CW-1:0]  px, py, pz;
    logic [CW-1:0]         rng;
    logic signed [AZW-1:0] az;
    logic signed [ELW-1:0] el;
  } sph_t;

  // Predicts each conversion and checks results in order
  class sph_scoreboard;
    sph_t predicted[$];
    int   n_points;
    int   n_checked;
    int   n_mismatch;

    // Vectoring CORDIC: drives vy to zero, accumulating the angle in degrees
    function void cordic_vectoring(inout longint vx, inout longint vy, inout longint ang);
      longint xs, ys;
      for (int i = 0; i < N_USED; i++) begin
        xs = vx >>> i;
        ys = vy >>> i;
        if (vy >= 0) begin
          vx = vx + ys;
          vy = vy - xs;
          ang = ang + longint'(c2s_pkg::ATAN_DEG[i]);
        end else begin
          vx = vx - ys;
          vy = vy + xs;
          ang = ang - longint'(c2s_pkg::ATAN_DEG[i]);
        end
      end
    endfunction

    // floor(a * g / 2^32), exact in 96 bits
    function longint scale_by_gain(longint a, logic [31:0] g);
      logic [95:0] p;
      p = {32'b0, a} * {64'b0, g};
      return longint'(p[95:32]);
    endfunction

    // Round half up to AFB fraction bits, then clamp to +/- deg
    function longint round_angle(longint a, longint deg);
      longint lim;
      int     sh;
      sh  = c2s_pkg::ACC_FRAC - AFB;
      lim = deg * (longint'(1) <<< AFB);
      if (sh > 0)
        a = (a + (longint'(1) <<< (sh - 1))) >>> sh;
      if (a > lim)
        a = lim;
      if (a < -lim)
        a = -lim;
      return a;
    endfunction

    function sph_t predict_spherical(logic signed [CW-1:0] px, py, pz);
      longint      x, y, z, vx, vy, a1, a2, hx, hy, r, rng;
      logic [31:0] g;
      bit          xy_zero;
      sph_t        e;
      x = longint'(px);
      y = longint'(py);
      z = longint'(pz);
      xy_zero = (x == 0 && y == 0);
      g = c2s_pkg::INV_GAIN[(N_USED > 16) ? 16 : N_USED];
      vx = x <<< c2s_pkg::GUARD_BITS;
      vy = y <<< c2s_pkg::GUARD_BITS;
      a1 = 0;
      a2 = 0;
      // left half-plane: fold over and start from +/-180
      if (vx < 0) begin
        vx = -vx;
        vy = -vy;
        a1 = (y >= 0) ? longint'(c2s_pkg::DEG180_Q) : -longint'(c2s_pkg::DEG180_Q);
      end
      cordic_vectoring(vx, vy, a1);
      hx = scale_by_gain(vx, g);
      hy = z <<< c2s_pkg::GUARD_BITS;
      cordic_vectoring(hx, hy, a2);
      r = scale_by_gain(hx, g);
      rng = (r + (longint'(1) <<< (c2s_pkg::GUARD_BITS - 1))) >>> c2s_pkg::GUARD_BITS;
      if (rng > (longint'(1) <<< CW) - 1)
        rng = (longint'(1) <<< CW) - 1;
      e.px  = px;
      e.py  = py;
      e.pz  = pz;
      e.rng = CW'(rng);
      e.az  = xy_zero ? '0 : AZW'(round_angle(a1, 180));
      e.el  = (xy_zero && z == 0) ? '0 : ELW'(round_angle(a2, 90));
      return e;
    endfunction

    function int pending();
      return predicted.size();
    endfunction

    function void note_point(logic signed [CW-1:0] px, py, pz);
      predicted.push_back(predict_spherical(px, py, pz));
      n_points++;
    endfunction

    task report(string msg);
      n_mismatch++;
      if (n_mismatch <= 40)
        $display("[%0t] MISMATCH %0d: %s", $realtime, n_mismatch, msg);
    endtask

    task check_result(logic [CW-1:0] rng, logic signed [AZW-1:0] az,
                      logic signed [ELW-1:0] el);
      sph_t  e;
      string pt;
      if (predicted.size() == 0) begin
        report($sformatf("result (%0d, %0d, %0d) with no point pending", rng, az, el));
      end else begin
        e  = predicted.pop_front();
        pt = $sformatf("(%0d,%0d,%0d)", e.px, e.py, e.pz);
        n_checked++;
        if (rng !== e.rng)
          report($sformatf("range_out for %s: got %0d, want %0d", pt, rng, e.rng));
        if (az !== e.az)
          report($sformatf("azimuth for %s: got %0d, want %0d", pt, az, e.az));
        if (el !== e.el)
          report($sformatf("elevation for %s: got %0d, want %0d", pt, el, e.el));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pos_valid = 1'b0;
  logic                  pos_ready;
  logic signed [CW-1:0]  pos_x = '0;
  logic signed [CW-1:0]  pos_y = '0;
  logic signed [CW-1:0]  pos_z = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [CW-1:0]         range_out;
  logic signed [AZW-1:0] azimuth;
  logic signed [ELW-1:0] elevation;

  bit steady   = 1'b0;
  bit hold_req = 1'b0;

  sph_scoreboard sb = new;

  cartesian_to_spherical #(
    .COORD_WIDTH     (CW),
    .ANGLE_FRAC_BITS (AFB),
    .CORDIC_STAGES   (STAGES)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .pos_valid (pos_valid),
    .pos_ready (pos_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .range_out (range_out),
    .azimuth   (azimuth),
    .elevation (elevation)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("timeout after %0d cycles, %0d results pending", TIMEOUT_CYCLES, sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: random stalls, a steady stretch, and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        res_ready <= 1'b1;
      end else if (steady) begin
        res_ready <= 1'b1;
      end else begin
        res_ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      sb.check_result(range_out, azimuth, elevation);
  end

  // Offer one point and wait for its transfer; valid stays up between back-to-back points
  task automatic offer_point(input logic signed [CW-1:0] x, y, z, input bit may_idle);
    if (may_idle && $urandom_range(99) < 15) begin
      pos_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    pos_valid <= 1'b1;
    pos_x     <= x;
    pos_y     <= y;
    pos_z     <= z;
    @(posedge clk);
    while (!pos_ready) @(posedge clk);
    sb.note_point(x, y, z);
  endtask

  // Stop sending until every predicted result has come back
  task automatic drain_results();
    pos_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    logic signed [CW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = CW'($urandom);
      4, 5:       v = CW'($urandom_range(32)) - CW'(16);
      6: begin
        case ($urandom_range(4))
          0:       v = CRD_HI;
          1:       v = CRD_LO;
          2:       v = CRD_HI - CW'(1);
          3:       v = CRD_LO + CW'(1);
          default: v = '1;
        endcase
      end
      default: begin
        // spread magnitudes across every scale
        v = CW'($urandom);
        v = v >>> $urandom_range(CW - 1);
      end
    endcase
    return v;
  endfunction

  initial begin
    logic signed [CW-1:0] rx, ry, rz;
    int                   wait_cnt;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: origin, axes, corners, folded half-plane and near +/-180
    offer_point(0, 0, 0, 1'b1);
    offer_point(0, 0, CRD_HI, 1'b1);
    offer_point(0, 0, CRD_LO, 1'b1);
    offer_point(0, 0, 1, 1'b1);
    offer_point(0, 0, -1, 1'b1);
    offer_point(CRD_HI, 0, 0, 1'b1);
    offer_point(CRD_LO, 0, 0, 1'b1);
    offer_point(-1, 0, 0, 1'b1);
    offer_point(1, 0, 0, 1'b1);
    offer_point(0, CRD_HI, 0, 1'b1);
    offer_point(0, CRD_LO, 0, 1'b1);
    offer_point(0, -1, 0, 1'b1);
    offer_point(CRD_HI, CRD_HI, CRD_HI, 1'b1);
    offer_point(CRD_LO, CRD_LO, CRD_LO, 1'b1);
    offer_point(CRD_HI, CRD_LO, 0, 1'b1);
    offer_point(CRD_LO, CRD_HI, 0, 1'b1);
    offer_point(CRD_LO, -1, 0, 1'b1);
    offer_point(CRD_LO, 1, 0, 1'b1);
    offer_point(CRD_HI, -1, 0, 1'b1);
    offer_point(CRD_LO, 0, CRD_HI, 1'b1);
    offer_point(CRD_LO, 0, CRD_LO, 1'b1);
    offer_point(-1, -1, -1, 1'b1);
    offer_point(1, 1, 1, 1'b1);
    offer_point(-5, 0, 3, 1'b1);
    offer_point(3, 4, 12, 1'b1);
    drain_results();

    // Random points; a steady stretch, a long output hold-off and a mid-run drain
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == PAUSE_AT)
        drain_results();
      if (i == HOLD_AT)
        hold_req = 1'b1;
      steady = (i >= STEADY_LO && i < STEADY_HI);
      rx = pick_coord();
      ry = pick_coord();
      rz = pick_coord();
      case ($urandom_range(19))
        0, 1: begin
          rx = '0;
          ry = '0;
        end
        2:       ry = '0;
        3:       rx = '0;
        default: ;
      endcase
      offer_point(rx, ry, rz, !steady && !(i >= HOLD_AT && i < HOLD_AT + 120));
    end
    steady = 1'b0;
    pos_valid <= 1'b0;

    for (wait_cnt = 0; sb.pending() != 0 && wait_cnt < 20000; wait_cnt++)
      @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
    // any stray result would surface here
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d points: axis, origin and corner cases, then random full-scale,",
             sb.n_points);
    $display("small and zeroed fields; %0d results checked across a %0d-cycle output stall",
             sb.n_checked, HOLD_CYCLES);
    if (sb.n_mismatch == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== cartesian_to_spherical.f =====
rtl/core/c2s_pkg.sv
rtl/core/c2s_cordic_stage.sv
rtl/core/c2s_gain.sv
rtl/core/cartesian_to_spherical.sv
test/cartesian_to_spherical_tb.sv
